>>> sv/wmmd_pkg.sv
// wmmd_pkg: widths, register map, reset values and queue entry type
// for the waveform min/max decimator; no dependencies
package wmmd_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int NUM_SAMPLES = 4;
  localparam int SUM_W       = 18;
  localparam int MAG_W       = 18;
  localparam int CH_W        = 3;
  localparam int FPB_W       = 24;
  localparam int BLK_W       = 13;
  localparam int IDX_W       = 12;
  localparam int ADDR_W      = 4;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;

  // x / 3 == (x * 43691) >> 17 for every x below 2**17
  localparam int DIV3_W     = 17;
  localparam int DIV3_MULT  = 43691;
  localparam int DIV3_SHIFT = 17;

  localparam int MAX_CHANNELS_DEF = 4;
  localparam int MAX_BLOCKS_DEF   = 4096;

  localparam logic [CH_W-1:0]  CHANNEL_COUNT_RST    = CH_W'(2);
  localparam logic [FPB_W-1:0] FRAMES_PER_BLOCK_RST = FPB_W'(1);
  localparam logic [BLK_W-1:0] BLOCK_COUNT_RST      = BLK_W'(1024);

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT    = 2'd0,
    REG_FRAMES_PER_BLOCK = 2'd1,
    REG_BLOCK_COUNT      = 2'd2
  } reg_index_t;

  // one classified frame: sign and magnitude of the channel sum, end-of-range flag
  typedef struct packed {
    logic             neg;
    logic [MAG_W-1:0] mag;
    logic             eor;
  } frame_t;

  // queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> sv/waveform_min_max_decimator.sv
// waveform_min_max_decimator: top level with register file, front,
// queue and back; uses wmmd_pkg, wmmd_front, wmmd_queue, wmmd_back
//
//   port group   dir  handshake             payload
//   in           in   in_valid / in_ready   sample_0..sample_3, end_of_range
//   out          out  out_valid / out_ready block_min, block_max, block_index,
//                                           final_block
//   register     in   psel/penable/pwrite   paddr, pwdata, prdata (pready high)
//
// one frame per cycle sustained while out_ready stays high; on its way to the
// output register a frame passes the front register, queue, divide stage and
// block update stage
// reset clears all control and block state and loads register defaults
// a stalled output register holds the block update stage, the two-entry queue
// then fills, and in_ready falls once the front register cannot drain
module waveform_min_max_decimator #(
  parameter int MAX_CHANNELS = wmmd_pkg::MAX_CHANNELS_DEF,
  parameter int MAX_BLOCKS   = wmmd_pkg::MAX_BLOCKS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // frame input
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_0,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_1,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_2,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_3,
  input  logic                                 end_of_range,
  // block output
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wmmd_pkg::SAMPLE_W-1:0] block_min,
  output logic signed [wmmd_pkg::SAMPLE_W-1:0] block_max,
  output logic [wmmd_pkg::IDX_W-1:0]           block_index,
  output logic                                 final_block,
  // register port
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wmmd_pkg::ADDR_W-1:0]          paddr,
  input  logic [wmmd_pkg::DATA_W-1:0]          pwdata,
  output logic [wmmd_pkg::DATA_W-1:0]          prdata,
  output logic                                 pready
);
  import wmmd_pkg::*;

  // the sample ports bound the usable channel count as well
  localparam int CH_LIM = (MAX_CHANNELS < NUM_SAMPLES) ? MAX_CHANNELS : NUM_SAMPLES;

  logic [CH_W-1:0]  channel_count;
  logic [FPB_W-1:0] frames_per_block;
  logic [BLK_W-1:0] block_count;

  logic [CH_W-1:0]  nch;
  logic [FPB_W-1:0] fpb;
  logic [BLK_W-1:0] nblk;

  logic             wr_en;
  reg_index_t       wr_index;

  logic             push;
  logic             pop;
  frame_t           push_data;
  frame_t           head;
  queue_status_t    q_status;

  // register file
  assign pready   = 1'b1;
  assign wr_en    = psel && penable && pwrite;
  assign wr_index = reg_index_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count    <= CHANNEL_COUNT_RST;
      frames_per_block <= FRAMES_PER_BLOCK_RST;
      block_count      <= BLOCK_COUNT_RST;
    end else if (wr_en) begin
      case (wr_index)
        REG_CHANNEL_COUNT:    channel_count    <= pwdata[CH_W-1:0];
        REG_FRAMES_PER_BLOCK: frames_per_block <= pwdata[FPB_W-1:0];
        REG_BLOCK_COUNT:      block_count      <= pwdata[BLK_W-1:0];
        default:              ;
      endcase
    end
  end

  always_comb begin
    case (wr_index)
      REG_CHANNEL_COUNT:    prdata = DATA_W'(channel_count);
      REG_FRAMES_PER_BLOCK: prdata = DATA_W'(frames_per_block);
      REG_BLOCK_COUNT:      prdata = DATA_W'(block_count);
      default:              prdata = '0;
    endcase
  end

  // effective settings: zero means one, large values clamp
  always_comb begin
    if (channel_count == '0) begin
      nch = CH_W'(1);
    end else if (int'(channel_count) > CH_LIM) begin
      nch = CH_W'(CH_LIM);
    end else begin
      nch = channel_count;
    end

    fpb = (frames_per_block == '0) ? FPB_W'(1) : frames_per_block;

    if (block_count == '0) begin
      nblk = BLK_W'(1);
    end else if (int'(block_count) > MAX_BLOCKS) begin
      nblk = BLK_W'(MAX_BLOCKS);
    end else begin
      nblk = block_count;
    end
  end

  // front: takes beats and forms the sign/magnitude channel sum
  wmmd_front u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_0     (sample_0),
    .sample_1     (sample_1),
    .sample_2     (sample_2),
    .sample_3     (sample_3),
    .end_of_range (end_of_range),
    .nch          (nch),
    .q_status     (q_status),
    .push         (push),
    .push_data    (push_data)
  );

  // queue decouples front stalls from back stalls
  wmmd_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .status    (q_status)
  );

  // back: average, block min/max, block counting, output register
  wmmd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .q_status    (q_status),
    .pop         (pop),
    .nch         (nch),
    .fpb         (fpb),
    .nblk        (nblk),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .block_min   (block_min),
    .block_max   (block_max),
    .block_index (block_index),
    .final_block (final_block)
  );

endmodule

>>> sv/wmmd_front.sv
// wmmd_front: accepts input beats, sums the active channels and
// registers sign and magnitude for the queue; uses wmmd_pkg
module wmmd_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_0,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_1,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_2,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_3,
  input  logic                           end_of_range,
  input  logic [wmmd_pkg::CH_W-1:0]      nch,
  input  wmmd_pkg::queue_status_t        q_status,
  output logic                           push,
  output wmmd_pkg::frame_t               push_data
);
  import wmmd_pkg::*;

  logic                       valid;
  frame_t                     frame;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] smp [NUM_SAMPLES];
  logic                       take;

  assign smp[0] = sample_0;
  assign smp[1] = sample_1;
  assign smp[2] = sample_2;
  assign smp[3] = sample_3;

  always_comb begin
    sum = '0;
    for (int i = 0; i < NUM_SAMPLES; i++) begin
      if (CH_W'(i) < nch) begin
        sum = sum + SUM_W'(smp[i]);
      end
    end
  end

  assign push      = valid && !q_status.full;
  assign in_ready  = !valid || !q_status.full;
  assign take      = in_valid && in_ready;
  assign push_data = frame;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (take) begin
      valid <= 1'b1;
    end else if (push) begin
      valid <= 1'b0;
    end
    if (take) begin
      frame.neg <= sum[SUM_W-1];
      frame.mag <= sum[SUM_W-1] ? MAG_W'(-sum) : MAG_W'(sum);
      frame.eor <= end_of_range;
    end
  end

endmodule

>>> sv/wmmd_queue.sv
// wmmd_queue: short first-in first-out queue of classified frames
// between front and back; uses wmmd_pkg
module wmmd_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  wmmd_pkg::frame_t        push_data,
  input  logic                    pop,
  output wmmd_pkg::frame_t        head,
  output wmmd_pkg::queue_status_t status
);
  import wmmd_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  frame_t             slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               do_push;
  logic               do_pop;

  assign status.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign status.empty = (count == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

>>> sv/wmmd_back.sv
// wmmd_back: divides by the channel count, tracks block min/max and
// block counters, and holds the output register; uses wmmd_pkg
module wmmd_back (
  input  logic                              clk,
  input  logic                              rst,
  input  wmmd_pkg::frame_t                  head,
  input  wmmd_pkg::queue_status_t           q_status,
  output logic                              pop,
  input  logic [wmmd_pkg::CH_W-1:0]         nch,
  input  logic [wmmd_pkg::FPB_W-1:0]        fpb,
  input  logic [wmmd_pkg::BLK_W-1:0]        nblk,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [wmmd_pkg::SAMPLE_W-1:0] block_min,
  output logic signed [wmmd_pkg::SAMPLE_W-1:0] block_max,
  output logic [wmmd_pkg::IDX_W-1:0]        block_index,
  output logic                              final_block
);
  import wmmd_pkg::*;

  localparam int PROD_W = 2 * DIV3_W;

  // divide stage
  logic                       s1_valid;
  logic signed [SAMPLE_W-1:0] s1_avg;
  logic                       s1_eor;
  logic [PROD_W-1:0]          prod;
  logic [SAMPLE_W-1:0]        quot;
  logic [SAMPLE_W-1:0]        avg_bits;
  logic                       s1_load;

  // block state
  logic signed [SAMPLE_W-1:0] running_min;
  logic signed [SAMPLE_W-1:0] running_max;
  logic [FPB_W-1:0]           frames_in_block;
  logic [BLK_W-1:0]           blocks_done;
  logic                       dropping;

  logic signed [SAMPLE_W-1:0] min_next;
  logic signed [SAMPLE_W-1:0] max_next;
  logic [FPB_W-1:0]           fib_next;
  logic                       close;
  logic                       last;
  logic                       s2_take;
  logic                       out_free;

  assign out_free = !out_valid || out_ready;
  assign s2_take  = s1_valid && out_free;
  assign s1_load  = !s1_valid || s2_take;
  assign pop      = s1_load && !q_status.empty;

  always_comb begin
    prod = PROD_W'(head.mag[DIV3_W-1:0]) * PROD_W'(DIV3_MULT);
    case (nch)
      CH_W'(1): quot = head.mag[SAMPLE_W-1:0];
      CH_W'(2): quot = head.mag[SAMPLE_W:1];
      CH_W'(3): quot = prod[DIV3_SHIFT +: SAMPLE_W];
      CH_W'(4): quot = head.mag[SAMPLE_W+1:2];
      default:  quot = head.mag[SAMPLE_W-1:0];
    endcase
    avg_bits = head.neg ? (~quot + 1'b1) : quot;
  end

  always_comb begin
    min_next = (s1_avg < running_min) ? s1_avg : running_min;
    max_next = (s1_avg > running_max) ? s1_avg : running_max;
    fib_next = frames_in_block + 1'b1;
    close    = s1_eor || (fib_next >= fpb);
    last     = s1_eor || ((BLK_W + 1)'(blocks_done) + 1'b1 >= (BLK_W + 1)'(nblk));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid        <= 1'b0;
      out_valid       <= 1'b0;
      running_min     <= '0;
      running_max     <= '0;
      frames_in_block <= '0;
      blocks_done     <= '0;
      dropping        <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid <= !q_status.empty;
      end
      if (s2_take && !dropping && close) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (s2_take) begin
        if (dropping) begin
          // frames are ignored until the end of the range
          if (s1_eor) begin
            dropping        <= 1'b0;
            blocks_done     <= '0;
            running_min     <= '0;
            running_max     <= '0;
            frames_in_block <= '0;
          end
        end else if (!close) begin
          running_min     <= min_next;
          running_max     <= max_next;
          frames_in_block <= fib_next;
        end else begin
          running_min     <= '0;
          running_max     <= '0;
          frames_in_block <= '0;
          if (s1_eor) begin
            blocks_done <= '0;
            dropping    <= 1'b0;
          end else if (last) begin
            blocks_done <= '0;
            dropping    <= 1'b1;
          end else begin
            blocks_done <= blocks_done + 1'b1;
          end
        end
      end
    end
    if (pop) begin
      s1_avg <= avg_bits;
      s1_eor <= head.eor;
    end
    if (s2_take && !dropping && close) begin
      block_min   <= min_next;
      block_max   <= max_next;
      block_index <= blocks_done[IDX_W-1:0];
      final_block <= last;
    end
  end

endmodule

>>> tb/wmmd_block_check.sv
`timescale 1ns / 1ps
// wmmd_block_check: watches the frame, block and register ports of the decimator,
// predicts every block summary and compares it; uses wmmd_pkg
module wmmd_block_check (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  input  logic                                 in_ready,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_0,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_1,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_2,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] sample_3,
  input  logic                                 end_of_range,
  input  logic                                 out_valid,
  input  logic                                 out_ready,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] block_min,
  input  logic signed [wmmd_pkg::SAMPLE_W-1:0] block_max,
  input  logic [wmmd_pkg::IDX_W-1:0]           block_index,
  input  logic                                 final_block,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [wmmd_pkg::ADDR_W-1:0]          paddr,
  input  logic [wmmd_pkg::DATA_W-1:0]          pwdata,
  input  logic                                 pready,
  output int                                   error_count,
  output int                                   pending,
  output int                                   frames_taken,
  output int                                   blocks_seen
);
  import wmmd_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] lo;
    logic signed [SAMPLE_W-1:0] hi;
    logic [IDX_W-1:0]           idx;
    logic                       last;
  } block_summary_t;

  // register mirror
  logic [CH_W-1:0]  chan_reg;
  logic [FPB_W-1:0] fpb_reg;
  logic [BLK_W-1:0] blk_reg;

  // block state
  logic signed [SAMPLE_W-1:0] run_lo;
  logic signed [SAMPLE_W-1:0] run_hi;
  logic [FPB_W-1:0]           frames_held;
  logic [BLK_W-1:0]           blocks_done;
  logic                       dropping;

  block_summary_t expected_blocks[$];
  block_summary_t want;

  task automatic report(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  task automatic clear_block();
    run_lo      = '0;
    run_hi      = '0;
    frames_held = '0;
  endtask

  // fold one accepted frame into the block, queue a summary when the block closes
  task automatic fold_frame(input logic signed [SAMPLE_W-1:0] s0, s1, s2, s3,
                            input logic eor);
    logic signed [SAMPLE_W-1:0] s[NUM_SAMPLES];
    block_summary_t b;
    int nch;
    int fpb;
    int nblk;
    int sum;
    int mag;
    int avg;
    int i;
    logic closes_range;
    nch  = (chan_reg == 0) ? 1 : int'(chan_reg);
    if (nch > MAX_CHANNELS_DEF) nch = MAX_CHANNELS_DEF;
    if (nch > NUM_SAMPLES) nch = NUM_SAMPLES;
    fpb  = (fpb_reg == 0) ? 1 : int'(fpb_reg);
    nblk = (blk_reg == 0) ? 1 : int'(blk_reg);
    if (nblk > MAX_BLOCKS_DEF) nblk = MAX_BLOCKS_DEF;

    if (dropping) begin
      if (eor) begin
        dropping    = 1'b0;
        blocks_done = '0;
        clear_block();
      end
      return;
    end

    s[0] = s0;
    s[1] = s1;
    s[2] = s2;
    s[3] = s3;
    sum = 0;
    for (i = 0; i < nch; i++) sum += s[i];
    // truncate toward zero
    mag = (sum < 0 ? -sum : sum) / nch;
    avg = (sum < 0) ? -mag : mag;

    if (avg < run_lo) run_lo = SAMPLE_W'(avg);
    if (avg > run_hi) run_hi = SAMPLE_W'(avg);
    frames_held++;

    if (!eor && frames_held < fpb) return;

    closes_range = eor || (blocks_done + 1 >= nblk);
    b.lo   = run_lo;
    b.hi   = run_hi;
    b.idx  = blocks_done[IDX_W-1:0];
    b.last = closes_range;
    expected_blocks = {expected_blocks, b};

    clear_block();
    if (eor) begin
      blocks_done = '0;
      dropping    = 1'b0;
    end else if (closes_range) begin
      blocks_done = '0;
      dropping    = 1'b1;
    end else begin
      blocks_done++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      chan_reg     = CHANNEL_COUNT_RST;
      fpb_reg      = FRAMES_PER_BLOCK_RST;
      blk_reg      = BLOCK_COUNT_RST;
      blocks_done  = '0;
      dropping     = 1'b0;
      clear_block();
      expected_blocks.delete();
      error_count  = 0;
      frames_taken = 0;
      blocks_seen  = 0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
        case (reg_index_t'(paddr[ADDR_W-1:2]))
          REG_CHANNEL_COUNT:    chan_reg = pwdata[CH_W-1:0];
          REG_FRAMES_PER_BLOCK: fpb_reg  = pwdata[FPB_W-1:0];
          REG_BLOCK_COUNT:      blk_reg  = pwdata[BLK_W-1:0];
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        if (expected_blocks.size() == 0) begin
          report($sformatf("block %0d arrived with nothing expected", blocks_seen));
        end else begin
          want = expected_blocks.pop_front();
          if (block_min !== want.lo)
            report($sformatf("block %0d min got %0d expected %0d",
                             blocks_seen, block_min, want.lo));
          if (block_max !== want.hi)
            report($sformatf("block %0d max got %0d expected %0d",
                             blocks_seen, block_max, want.hi));
          if (block_index !== want.idx)
            report($sformatf("block %0d index got %0d expected %0d",
                             blocks_seen, block_index, want.idx));
          if (final_block !== want.last)
            report($sformatf("block %0d final flag got %0b expected %0b",
                             blocks_seen, final_block, want.last));
        end
        blocks_seen++;
      end

      if (in_valid && in_ready) begin
        fold_frame(sample_0, sample_1, sample_2, sample_3, end_of_range);
        frames_taken++;
      end
    end
    pending <= expected_blocks.size();
  end

endmodule

>>> tb/waveform_min_max_decimator_test.sv
`timescale 1ns / 1ps
// waveform_min_max_decimator_test: drives frames and register writes into the
// decimator and gives the verdict; uses wmmd_pkg and wmmd_block_check
module waveform_min_max_decimator_test;
  import wmmd_pkg::*;

  localparam int RANDOM_FRAMES = 1250;
  localparam int CYCLE_LIMIT   = 500000;
  // pipeline is four deep; spare cycles let it drain before touching registers
  localparam int DRAIN_CYCLES  = 8;
  localparam logic signed [SAMPLE_W-1:0] S_MIN = -32768;
  localparam logic signed [SAMPLE_W-1:0] S_MAX = 32767;

  logic clk = 1'b0;
  logic rst = 1'b1;

  // frame channel
  logic                       in_valid     = 1'b0;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_0     = '0;
  logic signed [SAMPLE_W-1:0] sample_1     = '0;
  logic signed [SAMPLE_W-1:0] sample_2     = '0;
  logic signed [SAMPLE_W-1:0] sample_3     = '0;
  logic                       end_of_range = 1'b0;

  // block channel
  logic                       out_valid;
  logic                       out_ready    = 1'b0;
  logic signed [SAMPLE_W-1:0] block_min;
  logic signed [SAMPLE_W-1:0] block_max;
  logic [IDX_W-1:0]           block_index;
  logic                       final_block;

  // register port
  logic              psel    = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite  = 1'b0;
  logic [ADDR_W-1:0] paddr   = '0;
  logic [DATA_W-1:0] pwdata  = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  int error_count;
  int pending;
  int frames_taken;
  int blocks_seen;
  int cycles   = 0;
  int settings = 0;
  // when set, neither side idles: back-to-back beats for a whole phase
  bit steady   = 1'b0;

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d blocks still expected", cycles, pending);
      $display("*** FAILED ***");
      $finish;
    end
  end

  waveform_min_max_decimator u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_0     (sample_0),
    .sample_1     (sample_1),
    .sample_2     (sample_2),
    .sample_3     (sample_3),
    .end_of_range (end_of_range),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .block_min    (block_min),
    .block_max    (block_max),
    .block_index  (block_index),
    .final_block  (final_block),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  wmmd_block_check u_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .sample_0     (sample_0),
    .sample_1     (sample_1),
    .sample_2     (sample_2),
    .sample_3     (sample_3),
    .end_of_range (end_of_range),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .block_min    (block_min),
    .block_max    (block_max),
    .block_index  (block_index),
    .final_block  (final_block),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .error_count  (error_count),
    .pending      (pending),
    .frames_taken (frames_taken),
    .blocks_seen  (blocks_seen)
  );

  // gap before a frame beat: mostly none, some short, a few long
  function automatic int frame_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // length of a receiver stall, never zero
  function automatic int stall_len();
    if ($urandom_range(0, 99) < 80) return $urandom_range(1, 3);
    return $urandom_range(4, 40);
  endfunction

  // sample values lean on the extremes and on small values around zero,
  // where truncation toward zero and the zero start of min/max matter
  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return S_MIN;
    if (r < 16) return S_MAX;
    if (r < 36) return SAMPLE_W'($urandom_range(0, 8) - 4);
    return SAMPLE_W'($urandom());
  endfunction

  // receiver: random stalls unless the phase runs steady
  initial begin
    forever begin
      @(posedge clk);
      if (!steady && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat (stall_len()) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // two-phase register write; pready is waited on even though it is tied high
  task automatic reg_write(input reg_index_t idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_W'({idx, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic apply_setting(input logic [DATA_W-1:0] chans, fpb, blks);
    reg_write(REG_CHANNEL_COUNT, chans);
    reg_write(REG_FRAMES_PER_BLOCK, fpb);
    reg_write(REG_BLOCK_COUNT, blks);
    settings++;
  endtask

  // one frame beat; valid stays up between back-to-back frames and only
  // drops for a gap, so it is never lowered and raised in the same step
  task automatic send_frame(input logic signed [SAMPLE_W-1:0] a, b, c, d,
                            input logic eor);
    int gap;
    gap = frame_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    sample_0     <= a;
    sample_1     <= b;
    sample_2     <= c;
    sample_3     <= d;
    end_of_range <= eor;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic send_random_frame(input logic eor);
    logic signed [SAMPLE_W-1:0] same;
    // now and then every channel carries the same value
    if ($urandom_range(0, 9) == 0) begin
      same = pick_sample();
      send_frame(same, same, same, same, eor);
    end else begin
      send_frame(pick_sample(), pick_sample(), pick_sample(), pick_sample(), eor);
    end
  endtask

  // stop sending, wait for every expected block, then let frames that close
  // no block clear the pipeline before the registers are touched
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin
    int   phase_no;
    int   random_sent;
    int   in_phase;
    int   phase_len;
    int   range_len;
    int   pos;
    int   r;
    logic [DATA_W-1:0] chans;
    logic [DATA_W-1:0] fpb;
    logic [DATA_W-1:0] blks;
    longint fpb_eff;
    longint blk_eff;
    longint span;

    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // ---- directed part ----
    // reset settings: two channels, one frame per block, 1024 blocks
    send_frame(S_MIN, S_MIN, S_MAX, S_MAX, 1'b0);   // full-scale negative average
    send_frame(S_MAX, S_MAX, S_MIN, S_MIN, 1'b0);   // full-scale positive average
    send_frame(S_MIN, S_MAX, 16'sd0, 16'sd0, 1'b0); // sum -1 truncates to zero
    send_frame(-16'sd3, 16'sd0, S_MAX, S_MIN, 1'b0); // -1.5 truncates to -1
    send_frame(16'sd3, 16'sd0, S_MIN, S_MAX, 1'b0); // 1.5 truncates to 1
    send_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1); // range end resets the index
    settle();

    // four channels, three frames per block, two blocks per range
    apply_setting(32'd4, 32'd3, 32'd2);
    send_frame(S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);
    send_frame(S_MAX, S_MAX, S_MAX, S_MAX, 1'b0);
    send_frame(16'sd7, -16'sd9, 16'sd1, 16'sd0, 1'b0); // block 0 closes on count
    send_frame(16'sd100, 16'sd100, 16'sd100, 16'sd100, 1'b0);
    send_frame(-16'sd1, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_frame(16'sd1, 16'sd1, 16'sd1, 16'sd1, 1'b0); // block count reached, drop starts
    send_frame(S_MIN, S_MIN, S_MIN, S_MIN, 1'b0);     // dropped
    send_frame(S_MAX, S_MAX, S_MAX, S_MAX, 1'b1);     // range end while dropping: silent rearm
    send_frame(-16'sd200, 16'sd0, 16'sd0, 16'sd0, 1'b0);
    send_frame(16'sd400, 16'sd0, 16'sd0, 16'sd0, 1'b1); // early close on range end
    settle();

    // zero frames per block and zero blocks both read as one
    apply_setting(32'd3, 32'd0, 32'd0);
    send_frame(S_MIN, S_MIN, S_MIN, S_MAX, 1'b0);     // three-channel divide at full scale
    send_frame(S_MAX, S_MAX, S_MAX, S_MIN, 1'b0);     // dropped
    send_frame(16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1); // rearm
    send_frame(16'sd1, 16'sd1, 16'sd0, S_MIN, 1'b1);  // 2/3 truncates to zero
    settle();

    // channel count above four reads as four, block count above the maximum
    apply_setting(32'd7, 32'd2, 32'd8191);
    send_frame(S_MAX, S_MAX, S_MAX, S_MAX, 1'b0);
    send_frame(-16'sd1, -16'sd1, -16'sd1, -16'sd2, 1'b0);
    send_frame(16'sd5, -16'sd5, 16'sd0, 16'sd1, 1'b1);
    settle();

    // channel count zero reads as one
    apply_setting(32'd0, 32'd1, 32'd1024);
    send_frame(S_MIN, S_MAX, S_MAX, S_MAX, 1'b1);
    send_frame(S_MAX, S_MIN, S_MIN, S_MIN, 1'b1);
    settle();

    // ---- random part ----
    // each phase picks a register setting, then runs well-formed ranges:
    // a random run of frames closed by an end-of-range frame; the run length
    // goes up to three frames past the range's size, capped at 45, so the drop
    // state gets exercised, and an empty run gives a stray range end. Registers
    // change between phases only after a range end, so no block straddles new settings
    random_sent = 0;
    phase_no    = 0;
    while (random_sent < RANDOM_FRAMES) begin
      settle();
      if (phase_no == 0) begin
        chans = 32'd4; fpb = 32'd1; blks = 32'd1;
      end else if (phase_no == 1) begin
        chans = 32'd1; fpb = 32'd16777215; blks = 32'd4096;
      end else begin
        chans = ($urandom_range(0, 99) < 70) ? $urandom_range(1, 4) : $urandom_range(0, 7);
        r = $urandom_range(0, 99);
        if (r < 10) fpb = 32'd0;
        else if (r < 15) fpb = $urandom_range(100, 16777215);
        else if (r < 20) fpb = 32'd16777215;
        else fpb = $urandom_range(1, 6);
        r = $urandom_range(0, 99);
        if (r < 10) blks = 32'd0;
        else if (r < 15) blks = 32'd8191;
        else if (r < 20) blks = 32'd4096;
        else if (r < 25) blks = $urandom_range(4097, 8190);
        else blks = $urandom_range(1, 5);
      end
      apply_setting(chans, fpb, blks);
      steady = ($urandom_range(0, 4) == 0);

      // frames in one range before dropping starts, for shaping run lengths
      fpb_eff = longint'(fpb);
      if (fpb_eff == 0) fpb_eff = 1;
      blk_eff = longint'(blks);
      if (blk_eff == 0) blk_eff = 1;
      if (blk_eff > MAX_BLOCKS_DEF) blk_eff = MAX_BLOCKS_DEF;
      span    = fpb_eff * blk_eff;
      if (span > 45) span = 45;

      phase_len = $urandom_range(40, 140);
      in_phase  = 0;
      while (in_phase < phase_len && random_sent < RANDOM_FRAMES) begin
        range_len = $urandom_range(0, int'(span) + 3);
        for (pos = 0; pos < range_len; pos++) begin
          send_random_frame(1'b0);
          // frames past the span are not counted; below the cap they are the dropped ones
          if (pos < span) begin
            random_sent++;
            in_phase++;
          end
        end
        send_random_frame(1'b1);
        random_sent++;
        in_phase++;
      end
      phase_no++;
    end
    steady = 1'b0;

    settle();
    $display("covered %0d frames and %0d blocks over %0d register settings",
             frames_taken, blocks_seen, settings);
    $display("mismatches counted: %0d", error_count);
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> waveform_min_max_decimator.f
sv/wmmd_pkg.sv
sv/wmmd_front.sv
sv/wmmd_queue.sv
sv/wmmd_back.sv
sv/waveform_min_max_decimator.sv
tb/wmmd_block_check.sv
tb/waveform_min_max_decimator_test.sv
